// ----- sv/mc_pkg.sv -----
package mc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 32;
  localparam int SIZE_W    = 31;
  localparam int T_W       = FRAC_BITS + 1;
  localparam int POS_W     = VAL_W + 2;
  localparam int NUM_W     = VAL_W + 2;
  localparam int DEN_W     = VAL_W + 1;
  localparam int PROD_W    = SIZE_W + T_W;
  localparam int SUM_W     = POS_W + 2;

  typedef enum logic [1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_SIZE_X    = 2'd1,
    CFG_SIZE_Y    = 2'd2,
    CFG_SIZE_Z    = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_EMIT
  } seq_state_t;

  typedef enum logic [1:0] {
    T_ZERO,
    T_FULL,
    T_DIV
  } t_mode_t;

  // per-vertex data that rides alongside the divider
  typedef struct packed {
    logic                       last;
    logic [2:0]                 ca;
    logic [2:0]                 cb;
    logic [2:0][POS_W-1:0]      p0;
  } vtx_side_t;

  // triangle rows: top 'f' nibble marks the length, edges follow in hex, first edge highest
  localparam logic [63:0] TRI_ROWS [256] = '{
    64'hf, 64'hf083, 64'hf019, 64'hf183981,
    64'hf12a, 64'hf08312a, 64'hf92a029, 64'hf2832a8a98,
    64'hf3b2, 64'hf0b28b0, 64'hf19023b, 64'hf1b219b98b,
    64'hf3a1ba3, 64'hf0a108a8ba, 64'hf3903b9ba9, 64'hf98aa8b,
    64'hf478, 64'hf430734, 64'hf019847, 64'hf419471731,
    64'hf12a847, 64'hf34730412a, 64'hf92a902847, 64'hf2a9297273794,
    64'hf8473b2, 64'hfb47b24204, 64'hf90184723b, 64'hf47b94b9b2921,
    64'hf3a13ba784, 64'hf1ba14b1047b4, 64'hf47890b9bab03, 64'hf47b4b99ba,
    64'hf954, 64'hf954083, 64'hf054150, 64'hf854835315,
    64'hf12a954, 64'hf30812a495, 64'hf52a542402, 64'hf2a5325354348,
    64'hf95423b, 64'hf0b208b495, 64'hf05401523b, 64'hf21525828b485,
    64'hfa3ba13954, 64'hf4950818a18ba, 64'hf54050b5bab03, 64'hf54858aa8b,
    64'hf978579, 64'hf930953573, 64'hf078017157, 64'hf153357,
    64'hf978957a12, 64'hfa12950530573, 64'hf802825857a52, 64'hf2a5253357,
    64'hf7957893b2, 64'hf95797292027b, 64'hf23b018178157, 64'hfb21b17715,
    64'hf958857a13a3b, 64'hf5705097b010aba0, 64'hfba0b03a50807570, 64'hfba57b5,
    64'hfa65, 64'hf0835a6, 64'hf9015a6, 64'hf1831985a6,
    64'hf165261, 64'hf165126308, 64'hf965906026, 64'hf598582526328,
    64'hf23ba65, 64'hfb08b20a65, 64'hf01923b5a6, 64'hf5a61929b298b,
    64'hf63b653513, 64'hf08b0b50515b6, 64'hf3b6036065059, 64'hf65969bb98,
    64'hf5a6478, 64'hf43047365a, 64'hf1905a6847, 64'hfa65197173794,
    64'hf612651478, 64'hf125526304347, 64'hf847905065026, 64'hf739794329596269,
    64'hf3b2784a65, 64'hf5a647242027b, 64'hf01947823b5a6, 64'hf9219b294b7b45a6,
    64'hf8473b53515b6, 64'hf51b5b610b7b404b, 64'hf059065036b63847, 64'hf65969b4797b9,
    64'hfa4964a, 64'hf4a649a083, 64'hfa01a60640, 64'hf83181686461a,
    64'hf149124264, 64'hf308129249264, 64'hf024426, 64'hf832824426,
    64'hfa49a64b23, 64'hf08228b49a4a6, 64'hf3b201606461a, 64'hf64161a48121b8b1,
    64'hf964936913b63, 64'hf8b1810b61914641, 64'hf3b6360064, 64'hf648b68,
    64'hf7a678a89a, 64'hf0730a709a67a, 64'hfa671a7178180, 64'hfa67a71173,
    64'hf126168189867, 64'hf269291679093739, 64'hf780706602, 64'hf732672,
    64'hf23ba68a89867, 64'hf20727b09767a9a7, 64'hf1801781a767a23b, 64'hfb21b17a61671,
    64'hf896867916b63136, 64'hf091b67, 64'hf7807063b0b60, 64'hf7b6,
    64'hf76b, 64'hf308b76, 64'hf019b76, 64'hf819831b76,
    64'hfa126b7, 64'hf12a3086b7, 64'hf2902a96b7, 64'hf6b72a3a83a98,
    64'hf723627, 64'hf708760620, 64'hf276237019, 64'hf162186198876,
    64'hfa76a17137, 64'hfa7617a187108, 64'hf03707a0a96a7, 64'hf76a7a88a9,
    64'hf684b86, 64'hf36b306046, 64'hf86b846901, 64'hf946963931b36,
    64'hf6846b82a1, 64'hf12a30b06b046, 64'hf4b846b0292a9, 64'hfa93a32943b36463,
    64'hf823842462, 64'hf042462, 64'hf190234246438, 64'hf194142246,
    64'hf8138618466a1, 64'hfa10a06604, 64'hf4634386a3039a93, 64'hfa946a4,
    64'hf49576b, 64'hf083495b76, 64'hf50154076b, 64'hfb76834354315,
    64'hf954a1276b, 64'hf6b712a083495, 64'hf76b54a42a402, 64'hf348354325a52b76,
    64'hf723762549, 64'hf954086062687, 64'hf362376150540, 64'hf628687218485158,
    64'hf954a16176137, 64'hf16a176107870954, 64'hf40a4a503a6a737a, 64'hf76a7a854a48a,
    64'hf6956b9b89, 64'hf36b063056095, 64'hf0b805b01556b, 64'hf6b3635531,
    64'hf12a95b9b8b56, 64'hf0b306b09656912a, 64'hfb85b56805a52025, 64'hf6b36352a3a53,
    64'hf589528562382, 64'hf956960062, 64'hf158180568382628, 64'hf156216,
    64'hf13616a386569896, 64'hfa10a06950560, 64'hf03856a, 64'hfa56,
    64'hfb5a75b, 64'hfb5ab75830, 64'hf5b75ab190, 64'hfa75ab7981831,
    64'hfb12b71751, 64'hf08312717572b, 64'hf9759279022b7, 64'hf75272b592328982,
    64'hf25a235375, 64'hf820852875a25, 64'hf9015a35373a2, 64'hf982921872a25752,
    64'hf135375, 64'hf087071175, 64'hf903935537, 64'hf987597,
    64'hf5845a8ab8, 64'hf5045b05abb30, 64'hf01984a8aba45, 64'hfab4a45b34941314,
    64'hf2512852b8458, 64'hf04b0b345b2b151b, 64'hf0250592b5458b85, 64'hf9452b3,
    64'hf25a352345384, 64'hf5a2524420, 64'hf3a235a385458019, 64'hf5a2524192942,
    64'hf845853351, 64'hf045105, 64'hf845853905035, 64'hf945,
    64'hf4b749b9ab, 64'hf0834979b79ab, 64'hf1ab1b414074b, 64'hf3143481a474bab4,
    64'hf4b79b492b912, 64'hf9749b791b2b1083, 64'hfb74b42240, 64'hfb74b42834324,
    64'hf29a279237749, 64'hf9a7974a27870207, 64'hf37a3a274a1a040a, 64'hf1a2874,
    64'hf491417713, 64'hf491417081871, 64'hf403743, 64'hf487,
    64'hf9a8ab8, 64'hf30939bb9a, 64'hf01a0a88ab, 64'hf31ab3a,
    64'hf12b1b99b8, 64'hf30939b1292b9, 64'hf02b80b, 64'hf32b,
    64'hf23828aa89, 64'hf9a2092, 64'hf23828a0181a8, 64'hf1a2,
    64'hf138918, 64'hf091, 64'hf038, 64'hf
  };

  function automatic logic [2:0] edge_a(input logic [3:0] e);
    logic [2:0] c;
    case (e)
      4'd0, 4'd8:  c = 3'd0;
      4'd1, 4'd9:  c = 3'd1;
      4'd2, 4'd10: c = 3'd2;
      4'd3, 4'd11: c = 3'd3;
      4'd4:        c = 3'd4;
      4'd5:        c = 3'd5;
      4'd6:        c = 3'd6;
      4'd7:        c = 3'd7;
      default:     c = 3'd0;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] edge_b(input logic [3:0] e);
    logic [2:0] c;
    case (e)
      4'd0:        c = 3'd1;
      4'd1:        c = 3'd2;
      4'd2:        c = 3'd3;
      4'd3:        c = 3'd0;
      4'd4:        c = 3'd5;
      4'd5:        c = 3'd6;
      4'd6:        c = 3'd7;
      4'd7, 4'd8:  c = 3'd4;
      4'd9:        c = 3'd5;
      4'd10:       c = 3'd6;
      4'd11:       c = 3'd7;
      default:     c = 3'd0;
    endcase
    return c;
  endfunction

  // bit 0: +x, bit 1: +y, bit 2: +z
  function automatic logic [2:0] corner_axes(input logic [2:0] c);
    logic [2:0] a;
    case (c)
      3'd0:    a = 3'b000;
      3'd1:    a = 3'b100;
      3'd2:    a = 3'b110;
      3'd3:    a = 3'b010;
      3'd4:    a = 3'b001;
      3'd5:    a = 3'b101;
      3'd6:    a = 3'b111;
      3'd7:    a = 3'b011;
      default: a = 3'b000;
    endcase
    return a;
  endfunction

endpackage

// ----- sv/mc_in_if.sv -----
interface mc_in_if;
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       cell_origin_x;
  logic signed [31:0]       cell_origin_y;
  logic signed [31:0]       cell_origin_z;
  logic signed [31:0]       corner_value_0;
  logic signed [31:0]       corner_value_1;
  logic signed [31:0]       corner_value_2;
  logic signed [31:0]       corner_value_3;
  logic signed [31:0]       corner_value_4;
  logic signed [31:0]       corner_value_5;
  logic signed [31:0]       corner_value_6;
  logic signed [31:0]       corner_value_7;

  modport source (output valid, cell_origin_x, cell_origin_y, cell_origin_z,
                  corner_value_0, corner_value_1, corner_value_2, corner_value_3,
                  corner_value_4, corner_value_5, corner_value_6, corner_value_7,
                  input ready);
  modport sink (input valid, cell_origin_x, cell_origin_y, cell_origin_z,
                corner_value_0, corner_value_1, corner_value_2, corner_value_3,
                corner_value_4, corner_value_5, corner_value_6, corner_value_7,
                output ready);
endinterface

// ----- sv/mc_out_if.sv -----
interface mc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic signed [31:0] vertex_z;
  logic               last_vertex;

  modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
  modport sink (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

// ----- sv/mc_seq.sv -----
module mc_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic signed [31:0]            threshold,
  mc_in_if.sink                         in_ch,
  output logic                          sq_vld,
  output logic                          sq_last,
  output logic [2:0]                    sq_ca,
  output logic [2:0]                    sq_cb,
  output logic signed [31:0]            sq_va,
  output logic signed [31:0]            sq_vb,
  output logic [2:0][31:0]              sq_org
);

  mc_pkg::seq_state_t state_r, state_nxt;

  logic [7:0][31:0] vals_in;
  logic [7:0][31:0] vals_r;
  logic [2:0][31:0] org_r;
  logic [7:0]       code;
  logic [63:0]      row_in, row_r;
  logic [3:0]       len_in, len_r, k_r;
  logic [3:0]       idx;
  logic [3:0]       e;
  logic [2:0]       ca, cb;
  logic             take, emit, last;

  logic             vld_r, last_r;
  logic [2:0]       ca_r, cb_r;
  logic [31:0]      va_r, vb_r;
  logic [2:0][31:0] oorg_r;

  assign vals_in = {in_ch.corner_value_7, in_ch.corner_value_6, in_ch.corner_value_5,
                    in_ch.corner_value_4, in_ch.corner_value_3, in_ch.corner_value_2,
                    in_ch.corner_value_1, in_ch.corner_value_0};

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      code[i] = $signed(vals_in[i]) > threshold;
    end
    row_in = mc_pkg::TRI_ROWS[code];
    len_in = '0;
    for (int i = 0; i < 16; i++) begin
      if (row_in[4*i +: 4] == 4'hf) len_in = 4'(i);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mc_pkg::SEQ_IDLE: begin
        if (in_ch.valid && len_in != 4'd0) state_nxt = mc_pkg::SEQ_EMIT;
      end
      mc_pkg::SEQ_EMIT: begin
        if (adv && last) state_nxt = mc_pkg::SEQ_IDLE;
      end
      default: state_nxt = mc_pkg::SEQ_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready = 1'b0;
    emit        = 1'b0;
    case (state_r)
      mc_pkg::SEQ_IDLE: in_ch.ready = 1'b1;
      mc_pkg::SEQ_EMIT: emit = adv;
      default: begin
        in_ch.ready = 1'b0;
        emit        = 1'b0;
      end
    endcase
  end

  assign take = in_ch.valid && in_ch.ready;
  assign last = (k_r == len_r - 4'd1);
  assign idx  = len_r - 4'd1 - k_r;
  assign e    = row_r[{idx, 2'b00} +: 4];
  assign ca   = mc_pkg::edge_a(e);
  assign cb   = mc_pkg::edge_b(e);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mc_pkg::SEQ_IDLE;
      k_r     <= '0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (take) k_r <= '0;
      else if (emit) k_r <= k_r + 4'd1;
      if (adv) vld_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      vals_r <= vals_in;
      org_r  <= {in_ch.cell_origin_z, in_ch.cell_origin_y, in_ch.cell_origin_x};
      row_r  <= row_in;
      len_r  <= len_in;
    end
    if (emit) begin
      last_r <= last;
      ca_r   <= ca;
      cb_r   <= cb;
      va_r   <= vals_r[ca];
      vb_r   <= vals_r[cb];
      oorg_r <= org_r;
    end
  end

  assign sq_vld  = vld_r;
  assign sq_last = last_r;
  assign sq_ca   = ca_r;
  assign sq_cb   = cb_r;
  assign sq_va   = $signed(va_r);
  assign sq_vb   = $signed(vb_r);
  assign sq_org  = oorg_r;

endmodule

// ----- sv/mc_prep.sv -----
module mc_prep (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic signed [31:0]              threshold,
  input  logic [2:0][mc_pkg::SIZE_W-1:0]  size,
  input  logic                            sq_vld,
  input  logic                            sq_last,
  input  logic [2:0]                      sq_ca,
  input  logic [2:0]                      sq_cb,
  input  logic signed [31:0]              sq_va,
  input  logic signed [31:0]              sq_vb,
  input  logic [2:0][31:0]                sq_org,
  output logic                            pr_vld,
  output mc_pkg::vtx_side_t               pr_side,
  output mc_pkg::t_mode_t                 pr_mode,
  output logic [mc_pkg::DEN_W-1:0]        pr_num,
  output logic [mc_pkg::DEN_W-1:0]        pr_den
);

  // stage A: raw differences and edge start point
  logic                              a_vld_r;
  mc_pkg::vtx_side_t                 a_side_r;
  logic signed [mc_pkg::NUM_W-1:0]   a_num_r, a_den_r;
  mc_pkg::vtx_side_t                 a_side_nxt;

  always_comb begin
    a_side_nxt.last = sq_last;
    a_side_nxt.ca   = mc_pkg::corner_axes(sq_ca);
    a_side_nxt.cb   = mc_pkg::corner_axes(sq_cb);
    for (int ax = 0; ax < 3; ax++) begin
      a_side_nxt.p0[ax] = mc_pkg::POS_W'($signed(sq_org[ax]))
                        + (a_side_nxt.ca[ax] ? mc_pkg::POS_W'(size[ax]) : '0);
    end
  end

  // stage B: sign fold and classification
  logic                              b_vld_r;
  mc_pkg::vtx_side_t                 b_side_r;
  mc_pkg::t_mode_t                   b_mode_r, b_mode_nxt;
  logic [mc_pkg::DEN_W-1:0]          b_num_r, b_den_r;
  logic signed [mc_pkg::NUM_W-1:0]   n_f, d_f;

  always_comb begin
    if (a_den_r[mc_pkg::NUM_W-1]) begin
      n_f = -a_num_r;
      d_f = -a_den_r;
    end else begin
      n_f = a_num_r;
      d_f = a_den_r;
    end
    if (d_f == '0 || n_f[mc_pkg::NUM_W-1] || n_f == '0) b_mode_nxt = mc_pkg::T_ZERO;
    else if (n_f >= d_f)                                b_mode_nxt = mc_pkg::T_FULL;
    else                                                b_mode_nxt = mc_pkg::T_DIV;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= sq_vld;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_side_r <= a_side_nxt;
      a_num_r  <= mc_pkg::NUM_W'(threshold) - mc_pkg::NUM_W'(sq_va);
      a_den_r  <= mc_pkg::NUM_W'(sq_vb) - mc_pkg::NUM_W'(sq_va);
      b_side_r <= a_side_r;
      b_mode_r <= b_mode_nxt;
      b_num_r  <= n_f[mc_pkg::DEN_W-1:0];
      b_den_r  <= d_f[mc_pkg::DEN_W-1:0];
    end
  end

  assign pr_vld  = b_vld_r;
  assign pr_side = b_side_r;
  assign pr_mode = b_mode_r;
  assign pr_num  = b_num_r;
  assign pr_den  = b_den_r;

endmodule

// ----- sv/mc_div.sv -----
module mc_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic                            pr_vld,
  input  mc_pkg::vtx_side_t               pr_side,
  input  mc_pkg::t_mode_t                 pr_mode,
  input  logic [mc_pkg::DEN_W-1:0]        pr_num,
  input  logic [mc_pkg::DEN_W-1:0]        pr_den,
  output logic                            dv_vld,
  output mc_pkg::vtx_side_t               dv_side,
  output mc_pkg::t_mode_t                 dv_mode,
  output logic [mc_pkg::FRAC_BITS-1:0]    dv_q
);

  localparam int N = mc_pkg::FRAC_BITS;

  // one quotient bit per stage, restoring
  logic                           vld_r  [N];
  mc_pkg::vtx_side_t              side_r [N];
  mc_pkg::t_mode_t                mode_r [N];
  logic [mc_pkg::DEN_W-1:0]       rem_r  [N];
  logic [mc_pkg::DEN_W-1:0]       den_r  [N];
  logic [N-1:0]                   q_r    [N];

  for (genvar j = 0; j < N; j++) begin : g_st
    logic                         v_in;
    mc_pkg::vtx_side_t            s_in;
    mc_pkg::t_mode_t              m_in;
    logic [mc_pkg::DEN_W-1:0]     r_in, d_in;
    logic [N-1:0]                 q_in;
    logic [mc_pkg::DEN_W:0]       sh, df;

    if (j == 0) begin : g_first
      assign v_in = pr_vld;
      assign s_in = pr_side;
      assign m_in = pr_mode;
      assign r_in = pr_num;
      assign d_in = pr_den;
      assign q_in = '0;
    end else begin : g_next
      assign v_in = vld_r[j-1];
      assign s_in = side_r[j-1];
      assign m_in = mode_r[j-1];
      assign r_in = rem_r[j-1];
      assign d_in = den_r[j-1];
      assign q_in = q_r[j-1];
    end

    assign sh = {r_in, 1'b0};
    assign df = sh - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[j] <= 1'b0;
      else if (adv) vld_r[j] <= v_in;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[j] <= s_in;
        mode_r[j] <= m_in;
        den_r[j]  <= d_in;
        if (sh >= {1'b0, d_in}) begin
          rem_r[j] <= df[mc_pkg::DEN_W-1:0];
          q_r[j]   <= {q_in[N-2:0], 1'b1};
        end else begin
          rem_r[j] <= sh[mc_pkg::DEN_W-1:0];
          q_r[j]   <= {q_in[N-2:0], 1'b0};
        end
      end
    end
  end

  assign dv_vld  = vld_r[N-1];
  assign dv_side = side_r[N-1];
  assign dv_mode = mode_r[N-1];
  assign dv_q    = q_r[N-1];

endmodule

// ----- sv/mc_lerp.sv -----
module mc_lerp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic [2:0][mc_pkg::SIZE_W-1:0]  size,
  input  logic                            dv_vld,
  input  mc_pkg::vtx_side_t               dv_side,
  input  mc_pkg::t_mode_t                 dv_mode,
  input  logic [mc_pkg::FRAC_BITS-1:0]    dv_q,
  mc_out_if.source                        out_ch
);

  logic [mc_pkg::T_W-1:0]           t;
  logic                             m_vld_r;
  logic                             m_last_r;
  logic [2:0]                       m_neg_r;
  logic [2:0][mc_pkg::POS_W-1:0]    m_p0_r;
  logic [2:0][mc_pkg::PROD_W-1:0]   m_prod_r;

  logic                             o_vld_r, o_last_r;
  logic [2:0][31:0]                 o_pos_r;
  logic [2:0][31:0]                 pos_nxt;

  always_comb begin
    case (dv_mode)
      mc_pkg::T_ZERO: t = '0;
      mc_pkg::T_FULL: t = mc_pkg::T_W'(1) << mc_pkg::FRAC_BITS;
      mc_pkg::T_DIV:  t = {1'b0, dv_q};
      default:        t = '0;
    endcase
  end

  always_comb begin
    logic signed [mc_pkg::SUM_W-1:0] p0, off, s;
    for (int ax = 0; ax < 3; ax++) begin
      p0  = mc_pkg::SUM_W'($signed(m_p0_r[ax]));
      off = mc_pkg::SUM_W'(m_prod_r[ax][mc_pkg::PROD_W-1:mc_pkg::FRAC_BITS]);
      s   = m_neg_r[ax] ? p0 - off : p0 + off;
      if (s > mc_pkg::SUM_W'(32'sh7fffffff))      pos_nxt[ax] = 32'h7fffffff;
      else if (s < -mc_pkg::SUM_W'(33'sh80000000)) pos_nxt[ax] = 32'h80000000;
      else                                         pos_nxt[ax] = s[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else if (adv) begin
      m_vld_r <= dv_vld;
      o_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_last_r <= dv_side.last;
      m_p0_r   <= dv_side.p0;
      for (int ax = 0; ax < 3; ax++) begin
        m_neg_r[ax]  <= dv_side.ca[ax] & ~dv_side.cb[ax];
        m_prod_r[ax] <= (dv_side.ca[ax] ^ dv_side.cb[ax])
                        ? mc_pkg::PROD_W'(size[ax]) * mc_pkg::PROD_W'(t) : '0;
      end
      o_last_r <= m_last_r;
      o_pos_r  <= pos_nxt;
    end
  end

  assign out_ch.valid       = o_vld_r;
  assign out_ch.vertex_x    = $signed(o_pos_r[0]);
  assign out_ch.vertex_y    = $signed(o_pos_r[1]);
  assign out_ch.vertex_z    = $signed(o_pos_r[2]);
  assign out_ch.last_vertex = o_last_r;

endmodule

// ----- sv/marching_cubes_cell.sv -----
// A vertex passes the seq output register, prep stages A and B, the divider stages,
// the multiply and output registers. Throughput: one vertex per cycle unless stalled;
// a cell holds the input until its last vertex is emitted. The edge walk sets this rate.
// The datapath behind it (prep, 16-stage divider, multiply, output) takes one vertex
// per cycle and freezes as a whole while the output request waits.
// Reset (rst_n, synchronous): pipeline empty, threshold 0, cell sizes 4096.
module marching_cubes_cell (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wdata,
  mc_in_if.sink        in_ch,
  mc_out_if.source     out_ch
);

  // config registers
  logic signed [31:0]                threshold_r;
  logic [2:0][mc_pkg::SIZE_W-1:0]    size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= '0;
      size_r[0]   <= mc_pkg::SIZE_W'(4096);
      size_r[1]   <= mc_pkg::SIZE_W'(4096);
      size_r[2]   <= mc_pkg::SIZE_W'(4096);
    end else if (cfg_we) begin
      case (mc_pkg::cfg_idx_t'(cfg_index))
        mc_pkg::CFG_THRESHOLD: threshold_r <= $signed(cfg_wdata);
        mc_pkg::CFG_SIZE_X:    size_r[0]   <= cfg_wdata[mc_pkg::SIZE_W-1:0];
        mc_pkg::CFG_SIZE_Y:    size_r[1]   <= cfg_wdata[mc_pkg::SIZE_W-1:0];
        mc_pkg::CFG_SIZE_Z:    size_r[2]   <= cfg_wdata[mc_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // whole datapath advances when the output slot is free or being drained
  logic adv;
  assign adv = !out_ch.valid || out_ch.ready;

  logic                              sq_vld, sq_last;
  logic [2:0]                        sq_ca, sq_cb;
  logic signed [31:0]                sq_va, sq_vb;
  logic [2:0][31:0]                  sq_org;

  logic                              pr_vld;
  mc_pkg::vtx_side_t                 pr_side;
  mc_pkg::t_mode_t                   pr_mode;
  logic [mc_pkg::DEN_W-1:0]          pr_num, pr_den;

  logic                              dv_vld;
  mc_pkg::vtx_side_t                 dv_side;
  mc_pkg::t_mode_t                   dv_mode;
  logic [mc_pkg::FRAC_BITS-1:0]      dv_q;

  // case code, table row, one crossed edge per cycle while the datapath advances
  mc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .threshold (threshold_r),
    .in_ch     (in_ch),
    .sq_vld    (sq_vld),
    .sq_last   (sq_last),
    .sq_ca     (sq_ca),
    .sq_cb     (sq_cb),
    .sq_va     (sq_va),
    .sq_vb     (sq_vb),
    .sq_org    (sq_org)
  );

  // numerator/denominator, sign fold, edge start point
  mc_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .threshold (threshold_r),
    .size      (size_r),
    .sq_vld    (sq_vld),
    .sq_last   (sq_last),
    .sq_ca     (sq_ca),
    .sq_cb     (sq_cb),
    .sq_va     (sq_va),
    .sq_vb     (sq_vb),
    .sq_org    (sq_org),
    .pr_vld    (pr_vld),
    .pr_side   (pr_side),
    .pr_mode   (pr_mode),
    .pr_num    (pr_num),
    .pr_den    (pr_den)
  );

  // interpolation fraction, one bit per stage
  mc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .pr_vld  (pr_vld),
    .pr_side (pr_side),
    .pr_mode (pr_mode),
    .pr_num  (pr_num),
    .pr_den  (pr_den),
    .dv_vld  (dv_vld),
    .dv_side (dv_side),
    .dv_mode (dv_mode),
    .dv_q    (dv_q)
  );

  // size * t, offset from start corner, saturate, output register
  mc_lerp u_lerp (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .size    (size_r),
    .dv_vld  (dv_vld),
    .dv_side (dv_side),
    .dv_mode (dv_mode),
    .dv_q    (dv_q),
    .out_ch  (out_ch)
  );

endmodule
